@@ design/deq_pkg.sv @@
// shared types and constants for the double-ended queue
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEQ_DEPTH   = 16;
    localparam int WORD_W      = 32;
    localparam int OPCODE_W    = 3;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_PEEK       = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_LOAD,
        ST_OUT
    } deq_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_item;
        logic exec;
        logic rd_en;
        logic load_out;
    } deq_cmd_t;

endpackage

@@ design/deq_ram.sv @@
// generic ram with one write port and two registered read ports
`timescale 1ns / 1ps

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

@@ design/deq_ctrl.sv @@
// sequencing state machine for the double-ended queue
`timescale 1ns / 1ps

module deq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output deq_pkg::deq_cmd_t cmd
);

    deq_pkg::deq_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= deq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            deq_pkg::ST_IDLE: begin
                if (s_valid) state_next = deq_pkg::ST_EXEC;
            end
            deq_pkg::ST_EXEC: state_next = deq_pkg::ST_READ;
            deq_pkg::ST_READ: state_next = deq_pkg::ST_LOAD;
            deq_pkg::ST_LOAD: state_next = deq_pkg::ST_OUT;
            deq_pkg::ST_OUT: begin
                if (m_ready) state_next = deq_pkg::ST_IDLE;
            end
            default: state_next = deq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        cmd           = '0;
        case (state_reg)
            deq_pkg::ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            deq_pkg::ST_EXEC: cmd.exec     = 1'b1;
            deq_pkg::ST_READ: cmd.rd_en    = 1'b1;
            deq_pkg::ST_LOAD: cmd.load_out = 1'b1;
            deq_pkg::ST_OUT:  m_valid      = 1'b1;
            default: ;
        endcase
    end

    // one item in flight: never ready for input while a result is shown
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

    // an accepted word is executed in the following cycle
    a_exec_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> cmd.exec)
        else $error("accepted word not executed");

    // the result shows up right after the output registers are loaded
    a_out_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid)
        else $error("result not presented after load");

endmodule

@@ design/deq_datapath.sv @@
// pointers, count, slot memory and result registers of the queue
`timescale 1ns / 1ps

module deq_datapath #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  deq_pkg::deq_cmd_t                      cmd,
    input  logic [deq_pkg::OPCODE_W-1:0]           s_opcode,
    input  logic signed [deq_pkg::WORD_W-1:0]      s_push_value,
    output logic signed [deq_pkg::WORD_W-1:0]      m_front_value,
    output logic signed [deq_pkg::WORD_W-1:0]      m_back_value,
    output logic [deq_pkg::COUNT_OUT_W-1:0]        m_element_count,
    output logic                                   m_is_empty,
    output logic                                   m_underflow,
    output logic                                   m_overflow
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? LAST_IDX : i - IDX_W'(1);
    endfunction

    deq_pkg::op_t                  op_reg;
    logic [deq_pkg::WORD_W-1:0]    val_reg;
    logic [IDX_W-1:0]              head_reg, head_next;
    logic [IDX_W-1:0]              tail_reg, tail_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          under_reg, under_next;
    logic                          over_reg, over_next;
    logic [deq_pkg::WORD_W-1:0]    front_reg, back_reg;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    logic                          is_full, is_zero;
    logic [deq_pkg::WORD_W-1:0]    rd_front, rd_back;

    assign is_full = (count_reg == FULL_CNT);
    assign is_zero = (count_reg == '0);

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        under_next = 1'b0;
        over_next  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = tail_reg;
        case (op_reg)
            deq_pkg::OP_PUSH_BACK: begin
                if (is_full) begin
                    over_next = 1'b1;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = tail_reg;
                    tail_next  = wrap_inc(tail_reg);
                    count_next = count_reg + CNT_W'(1);
                end
            end
            deq_pkg::OP_PUSH_FRONT: begin
                if (is_full) begin
                    over_next = 1'b1;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = wrap_dec(head_reg);
                    head_next  = wrap_dec(head_reg);
                    count_next = count_reg + CNT_W'(1);
                end
            end
            deq_pkg::OP_POP_BACK: begin
                if (is_zero) begin
                    under_next = 1'b1;
                end else begin
                    tail_next  = wrap_dec(tail_reg);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                if (is_zero) begin
                    under_next = 1'b1;
                end else begin
                    head_next  = wrap_inc(head_reg);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            deq_pkg::OP_CLEAR: begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            default: ;  // peek and unused codes leave the state alone
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.exec) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg  <= deq_pkg::op_t'(s_opcode);
            val_reg <= s_push_value;
        end
        if (cmd.exec) begin
            under_reg <= under_next;
            over_reg  <= over_next;
        end
        if (cmd.load_out) begin
            front_reg <= is_zero ? '0 : rd_front;
            back_reg  <= is_zero ? '0 : rd_back;
        end
    end

    deq_ram #(
        .WIDTH (deq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .aclk    (aclk),
        .we      (cmd.exec && wr_en),
        .waddr   (wr_addr),
        .wdata   (val_reg),
        .re      (cmd.rd_en),
        .raddr_a (head_reg),
        .raddr_b (wrap_dec(tail_reg)),
        .rdata_a (rd_front),
        .rdata_b (rd_back)
    );

    assign m_front_value   = front_reg;
    assign m_back_value    = back_reg;
    assign m_element_count = deq_pkg::COUNT_OUT_W'(count_reg);
    assign m_is_empty      = is_zero;
    assign m_underflow     = under_reg;
    assign m_overflow      = over_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("count above depth");

    a_count_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == FULL_CNT) |-> (head_reg == tail_reg))
        else $error("pointers disagree with count");

    a_flag_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && (under_next || over_next))
            |=> (count_reg == $past(count_reg) && head_reg == $past(head_reg)))
        else $error("state changed on rejected operation");

    a_one_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> !(under_next && over_next))
        else $error("underflow and overflow together");

endmodule

@@ design/double_ended_queue.sv @@
// top level of the bounded double-ended queue
`timescale 1ns / 1ps

//  channel | handshake         | payload
//  --------+-------------------+------------------------------------------------
//  input   | s_valid / s_ready | s_opcode, s_push_value
//  result  | m_valid / m_ready | m_front_value, m_back_value, m_element_count,
//          |                   | m_is_empty, m_underflow, m_overflow
//
//  one word at a time: accept, then execute, read, load, and the result is
//  valid in the output state; no new word is accepted before it is taken
//  these steps come from the pass through the single slot memory, whose read
//  is registered and follows the write of the same operation
//  m_ready low holds the result and keeps s_ready low until it is taken
//  aresetn (synchronous) empties the queue; slot contents are not cleared

module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [deq_pkg::OPCODE_W-1:0]           s_opcode,
    input  logic signed [deq_pkg::WORD_W-1:0]      s_push_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [deq_pkg::WORD_W-1:0]      m_front_value,
    output logic signed [deq_pkg::WORD_W-1:0]      m_back_value,
    output logic [deq_pkg::COUNT_OUT_W-1:0]        m_element_count,
    output logic                                   m_is_empty,
    output logic                                   m_underflow,
    output logic                                   m_overflow
);

    // command bundle from the sequencer into the datapath
    deq_pkg::deq_cmd_t cmd;

    // controller: walks each word through execute, read and load
    deq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // datapath: head/tail/count, slot ram and the result registers
    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .s_opcode        (s_opcode),
        .s_push_value    (s_push_value),
        .m_front_value   (m_front_value),
        .m_back_value    (m_back_value),
        .m_element_count (m_element_count),
        .m_is_empty      (m_is_empty),
        .m_underflow     (m_underflow),
        .m_overflow      (m_overflow)
    );

endmodule

@@ dv/double_ended_queue_tb.sv @@
// self-checking testbench for the double-ended queue, with a mirror model and random traffic
`timescale 1ns / 1ps

module double_ended_queue_tb;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_LEN   = 9;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 20;     // cycles after the last word, well past the latency
    localparam int IDLE_PCT    = 18;
    localparam int HOLD_LEN    = 300;    // long receiver stall for the back-pressure test
    localparam int REPORT_MAX  = 10;
    localparam int IDX_W       = $clog2(deq_pkg::DEQ_DEPTH);

    // opcodes six and seven are not in the package enum; the block treats them as peek
    localparam logic [deq_pkg::OPCODE_W-1:0] OP_SPARE_SIX   = 3'd6;
    localparam logic [deq_pkg::OPCODE_W-1:0] OP_SPARE_SEVEN = 3'd7;

    typedef logic [IDX_W-1:0] idx_t;

    // one result word as the block reports it
    typedef struct packed {
        logic [deq_pkg::WORD_W-1:0]      front;
        logic [deq_pkg::WORD_W-1:0]      back;
        logic [deq_pkg::COUNT_OUT_W-1:0] count;
        logic                            empty;
        logic                            underflow;
        logic                            overflow;
    } deq_status_t;

    logic                                aclk            = 1'b0;
    logic                                aresetn         = 1'b0;
    logic                                s_valid         = 1'b0;
    logic                                s_ready;
    logic [deq_pkg::OPCODE_W-1:0]        s_opcode        = '0;
    logic signed [deq_pkg::WORD_W-1:0]   s_push_value    = '0;
    logic                                m_valid;
    logic                                m_ready         = 1'b0;
    logic signed [deq_pkg::WORD_W-1:0]   m_front_value;
    logic signed [deq_pkg::WORD_W-1:0]   m_back_value;
    logic [deq_pkg::COUNT_OUT_W-1:0]     m_element_count;
    logic                                m_is_empty;
    logic                                m_underflow;
    logic                                m_overflow;

    // mirror of the queue contents, advanced at every accepted input word
    logic [deq_pkg::WORD_W-1:0]      mirror_slots [deq_pkg::DEQ_DEPTH];
    idx_t                            mirror_head  = '0;
    idx_t                            mirror_tail  = '0;
    logic [deq_pkg::COUNT_OUT_W-1:0] mirror_count = '0;

    // status words still owed by the block, oldest first
    deq_status_t status_fifo [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  src_idle_on    = 1'b1;
    bit  snk_idle_on    = 1'b1;
    int  hold_request   = 0;    // set by a test, picked up by the receiver process
    int  hold_left      = 0;

    double_ended_queue DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_push_value    (s_push_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_front_value   (m_front_value),
        .m_back_value    (m_back_value),
        .m_element_count (m_element_count),
        .m_is_empty      (m_is_empty),
        .m_underflow     (m_underflow),
        .m_overflow      (m_overflow)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // hard stop in case the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, status_fifo.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // circular index arithmetic of the mirror
    function automatic idx_t idx_up(input idx_t i);
        return idx_t'((i + 1) % deq_pkg::DEQ_DEPTH);
    endfunction

    function automatic idx_t idx_down(input idx_t i);
        return idx_t'((i + deq_pkg::DEQ_DEPTH - 1) % deq_pkg::DEQ_DEPTH);
    endfunction

    // apply one operation to the mirror and queue the status it should produce
    function automatic void mirror_apply(input logic [deq_pkg::OPCODE_W-1:0] op,
                                         input logic [deq_pkg::WORD_W-1:0] val);
        deq_status_t st;
        st = '0;
        case (op)
            deq_pkg::OP_PUSH_BACK: begin
                if (mirror_count >= deq_pkg::DEQ_DEPTH) begin
                    st.overflow = 1'b1;                 // full: word dropped
                end else begin
                    mirror_slots[mirror_tail] = val;
                    mirror_tail  = idx_up(mirror_tail);
                    mirror_count = mirror_count + 1'b1;
                end
            end
            deq_pkg::OP_PUSH_FRONT: begin
                if (mirror_count >= deq_pkg::DEQ_DEPTH) begin
                    st.overflow = 1'b1;
                end else begin
                    mirror_head  = idx_down(mirror_head);
                    mirror_slots[mirror_head] = val;
                    mirror_count = mirror_count + 1'b1;
                end
            end
            deq_pkg::OP_POP_BACK: begin
                if (mirror_count == 0) begin
                    st.underflow = 1'b1;                // empty: state untouched
                end else begin
                    mirror_tail  = idx_down(mirror_tail);
                    mirror_count = mirror_count - 1'b1;
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                if (mirror_count == 0) begin
                    st.underflow = 1'b1;
                end else begin
                    mirror_head  = idx_up(mirror_head);
                    mirror_count = mirror_count - 1'b1;
                end
            end
            deq_pkg::OP_CLEAR: begin
                // pointers only, slot contents stay behind
                mirror_head  = '0;
                mirror_tail  = '0;
                mirror_count = '0;
            end
            default: begin
                // peek and the two spare codes change nothing
            end
        endcase
        if (mirror_count != 0) begin
            st.front = mirror_slots[mirror_head];
            st.back  = mirror_slots[idx_down(mirror_tail)];
        end
        st.count = mirror_count;
        st.empty = (mirror_count == 0);
        status_fifo.insert(status_fifo.size(), st);
    endfunction

    function automatic void report_mismatch(input string what, input deq_status_t want,
                                            input deq_status_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("%0t %s", $realtime, what);
            $display("    expected front=%0d back=%0d count=%0d empty=%0b under=%0b over=%0b",
                     $signed(want.front), $signed(want.back), want.count, want.empty,
                     want.underflow, want.overflow);
            $display("    actual   front=%0d back=%0d count=%0d empty=%0b under=%0b over=%0b",
                     $signed(got.front), $signed(got.back), got.count, got.empty,
                     got.underflow, got.overflow);
        end
    endfunction

    // result side: compare every accepted word with the oldest expectation
    always @(posedge aclk) begin : result_check
        deq_status_t got;
        deq_status_t want;
        if (aresetn && m_valid && m_ready) begin
            got.front     = m_front_value;
            got.back      = m_back_value;
            got.count     = m_element_count;
            got.empty     = m_is_empty;
            got.underflow = m_underflow;
            got.overflow  = m_overflow;
            if (status_fifo.size() == 0) begin
                report_mismatch("result word with nothing expected", '0, got);
            end else begin
                want = status_fifo[0];
                status_fifo.delete(0);
                if (got !== want) begin
                    report_mismatch("result word differs", want, got);
                end
            end
        end
    end

    // receiver: random stalls, plus a long counted hold-off when a test asks for one
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= !(snk_idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // offer one word and return at the edge where it is taken;
    // valid is left high so a following word can go out back to back
    task automatic send_word(input logic [deq_pkg::OPCODE_W-1:0] op,
                             input logic [deq_pkg::WORD_W-1:0] val);
        while (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_push_value <= val;
        do @(posedge aclk); while (!s_ready);
        mirror_apply(op, val);
    endtask

    // stop offering and wait for every owed result word
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (status_fifo.size() != 0) @(posedge aclk);
    endtask

    // random payload with the sign and zero extremes showing up now and then
    function automatic logic [deq_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [deq_pkg::OPCODE_W-1:0] pick_op();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 28) return deq_pkg::OP_PUSH_BACK;
        if (r < 56) return deq_pkg::OP_PUSH_FRONT;
        if (r < 70) return deq_pkg::OP_POP_BACK;
        if (r < 84) return deq_pkg::OP_POP_FRONT;
        if (r < 88) return deq_pkg::OP_CLEAR;
        if (r < 94) return deq_pkg::OP_PEEK;
        if (r < 97) return OP_SPARE_SIX;
        return OP_SPARE_SEVEN;
    endfunction

    function automatic logic [deq_pkg::OPCODE_W-1:0] pick_push();
        return $urandom_range(1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
    endfunction

    function automatic logic [deq_pkg::OPCODE_W-1:0] pick_pop();
        return $urandom_range(1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
    endfunction

    // pops, peeks and spare codes on an empty queue
    task automatic test_empty_queue();
        send_word(deq_pkg::OP_POP_BACK, pick_word());
        send_word(deq_pkg::OP_POP_FRONT, pick_word());
        send_word(deq_pkg::OP_PEEK, pick_word());
        send_word(OP_SPARE_SIX, pick_word());
        send_word(OP_SPARE_SEVEN, pick_word());
        wait_drained();
    endtask

    // alternate back and front pushes until full, so the head wraps below slot zero,
    // then push once more at each end
    task automatic test_fill_overflow();
        logic [deq_pkg::WORD_W-1:0] edge_vals [4];
        edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
        for (int i = 0; i < deq_pkg::DEQ_DEPTH; i++) begin
            send_word(i[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
                      (i < 4) ? edge_vals[i] : $urandom);
        end
        send_word(deq_pkg::OP_PUSH_BACK, pick_word());
        send_word(deq_pkg::OP_PUSH_FRONT, pick_word());
        wait_drained();
    endtask

    // clear a full queue, then look at it
    task automatic test_clear();
        send_word(deq_pkg::OP_CLEAR, pick_word());
        send_word(deq_pkg::OP_PEEK, pick_word());
        wait_drained();
    endtask

    // well-formed rounds: fill to a level, maybe overflow, then drain or clear,
    // finishing with a pop or two on the empty queue
    task automatic test_fill_drain();
        int unsigned level;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        for (int round = 0; round < 9; round++) begin
            level = (round % 3 == 0) ? deq_pkg::DEQ_DEPTH
                                     : $urandom_range(deq_pkg::DEQ_DEPTH, 1);
            while (mirror_count < level) begin
                send_word(pick_push(), pick_word());
                if ($urandom_range(9) == 0) send_word(deq_pkg::OP_PEEK, pick_word());
            end
            if (mirror_count == deq_pkg::DEQ_DEPTH) begin
                repeat ($urandom_range(2, 1)) send_word(pick_push(), pick_word());
            end
            if (round % 4 == 3) begin
                send_word(deq_pkg::OP_CLEAR, pick_word());
            end else begin
                while (mirror_count != 0) send_word(pick_pop(), pick_word());
            end
            repeat ($urandom_range(2, 1)) send_word(pick_pop(), pick_word());
        end
        wait_drained();
    endtask

    // free-running random operations; occasionally the sender waits for the results
    task automatic run_random_ops(input int n_words, input bit with_pauses);
        for (int i = 0; i < n_words; i++) begin
            send_word(pick_op(), pick_word());
            if (with_pauses && $urandom_range(49) == 0) wait_drained();
        end
        wait_drained();
    endtask

    task automatic test_random_mix();
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        run_random_ops(400, 1'b1);
    endtask

    // long stretch at full rate, neither side idling
    task automatic test_steady_stream();
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        run_random_ops(100, 1'b0);
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
    endtask

    // receiver holds off for a long time while the sender keeps offering,
    // so the block backs up and drops s_ready
    task automatic test_backpressure();
        src_idle_on  = 1'b0;
        hold_request = HOLD_LEN;
        for (int i = 0; i < 12; i++) begin
            send_word(pick_op(), pick_word());
        end
        wait_drained();
        src_idle_on = 1'b1;
    endtask

    initial begin
        repeat (RESET_LEN) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_queue();
        test_fill_overflow();
        test_clear();
        test_fill_drain();
        test_random_mix();
        test_steady_stream();
        test_backpressure();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0 && status_fifo.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ double_ended_queue.f @@
design/deq_pkg.sv
design/deq_ram.sv
design/deq_ctrl.sv
design/deq_datapath.sv
design/double_ended_queue.sv
dv/double_ended_queue_tb.sv
